>>> hw/rtl/telemetry_command_deframer_macros.svh
// Assertion helpers for the command deframer.
// Each macro expects clk and rst_n in scope and is held off while reset is asserted.
`ifndef TELEMETRY_COMMAND_DEFRAMER_MACROS_SVH
`define TELEMETRY_COMMAND_DEFRAMER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TCD_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("deframer same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define TCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("deframer next-cycle check failed");

`endif

>>> hw/rtl/tcd_pkg.sv
`default_nettype none

package tcd_pkg;

    localparam int BYTE_W   = 8;
    localparam int ACTION_W = 3;
    localparam int SLOT_W   = 4;
    localparam int VALUE_W  = 17;

    localparam int STORED_BYTES_DEF = 20;
    localparam int RUN_MAX          = 11;

    localparam logic [7:0] HDR0     = 8'hAA;
    localparam logic [7:0] HDR1     = 8'hAF;
    localparam logic [7:0] HEAD_SUM = 8'h59;

    localparam logic [7:0] FUNC_CAL      = 8'h01;
    localparam logic [7:0] FUNC_REQ      = 8'h02;
    localparam logic [7:0] FUNC_ANGLE    = 8'h03;
    localparam logic [7:0] FUNC_GAIN     = 8'h10;
    localparam logic [7:0] FUNC_ACK_LO   = 8'h11;
    localparam logic [7:0] FUNC_ACK_2    = 8'h12;
    localparam logic [7:0] FUNC_ACK_3    = 8'h13;
    localparam logic [7:0] FUNC_ACK_4    = 8'h14;
    localparam logic [7:0] FUNC_ACK_HI   = 8'h15;

    localparam logic [7:0] SUB_GYRO = 8'h02;
    localparam logic [7:0] SUB_MAG  = 8'h04;
    localparam logic [7:0] SUB_PID  = 8'h01;

    localparam logic [ACTION_W-1:0] ACT_GYRO_CAL = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_MAG_CAL  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_PID_REQ  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_ANGLE    = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_GAIN     = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_ACK      = 3'd5;
    localparam logic [ACTION_W-1:0] ACT_SAVE     = 3'd6;

endpackage

`default_nettype wire

>>> hw/rtl/tcd_in_if.sv
`default_nettype none

interface tcd_in_if;
    import tcd_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/tcd_out_if.sv
`default_nettype none

interface tcd_out_if;
    import tcd_pkg::*;

    logic                      valid;
    logic                      ready;
    logic [ACTION_W-1:0]       action;
    logic [SLOT_W-1:0]         slot;
    logic signed [VALUE_W-1:0] value;
    logic [BYTE_W-1:0]         ack_sum;
    logic                      last;

    modport source (output valid, output action, output slot, output value,
                    output ack_sum, output last, input ready);
    modport sink   (input valid, input action, input slot, input value,
                    input ack_sum, input last, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/telemetry_command_deframer.sv
// Command deframer: takes one received byte per beat on cmd, finds frames that start with
// 0xAA 0xAF, carry a function code and a length byte, and end with an 8-bit sum over every
// earlier frame byte, and turns each frame whose sum matches into a run of action beats on
// act, the final beat of a run marked by last. A byte is taken in every cycle while no run
// is pending. After a matching check byte, cmd is held off until the last action of the run
// (eleven for a gain frame) has gone into the result register, or until the frame is found
// to decode to no action. The result register cannot move on while act is stalled, and the
// actions are read out of the frame byte store one per cycle in which it is free.
// Frame bytes from position 2 up to STORED_BYTES+1 are kept in that store, which reset
// clears, so a short frame decodes whatever earlier frames left in it.
`default_nettype none

`include "telemetry_command_deframer_macros.svh"

module telemetry_command_deframer #(
    parameter int STORED_BYTES = tcd_pkg::STORED_BYTES_DEF
) (
    input  wire        clk,
    input  wire        rst_n,
    tcd_in_if.sink     cmd,
    tcd_out_if.source  act
);
    import tcd_pkg::*;

    localparam int IDX_W = $clog2(STORED_BYTES);

    // Frame sync state. The spare code falls back to hunting.
    typedef enum logic [1:0] {
        PH_HUNT  = 2'd0,
        PH_HEAD2 = 2'd1,
        PH_BODY  = 2'd2
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [8:0]  pos_reg, pos_next;
    logic [7:0]  len_reg, len_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  store_reg [STORED_BYTES];

    // Action run sequencer and the result register.
    logic        run_active_reg, run_active_next;
    logic [3:0]  idx_reg, idx_next;
    logic [7:0]  run_sum_reg;

    logic                      out_valid_reg, out_valid_next;
    logic [ACTION_W-1:0]       out_action_reg, out_action_next;
    logic [SLOT_W-1:0]         out_slot_reg, out_slot_next;
    logic signed [VALUE_W-1:0] out_value_reg, out_value_next;
    logic [BYTE_W-1:0]         out_sum_reg, out_sum_next;
    logic                      out_last_reg, out_last_next;

    logic       accept_in;
    logic [7:0] rx;
    logic       run_start;
    logic [8:0] len_end;
    logic [8:0] pos_minus2;
    logic       store_we;
    logic [IDX_W-1:0] wr_idx;

    logic [7:0]  func;
    logic [7:0]  sub;
    logic [3:0]  run_count;
    logic        out_free;
    logic        load;
    logic        load_last;

    logic [VALUE_W-1:0] gain_word  [9];
    logic [VALUE_W-1:0] angle_word [3];

    assign cmd.ready  = !run_active_reg;
    assign accept_in  = cmd.valid && !run_active_reg;
    assign rx         = cmd.rx_byte;
    assign len_end    = {1'b0, len_reg} + 9'd4;
    assign pos_minus2 = pos_reg - 9'd2;
    assign wr_idx     = pos_minus2[IDX_W-1:0];
    assign store_we   = accept_in && (phase_reg == PH_BODY) && (pos_reg >= 9'd2)
                        && (pos_minus2 < 9'(STORED_BYTES));

    // Byte parser. The check byte is compared against the sum of everything before it.
    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        sum_next   = sum_reg;
        run_start  = 1'b0;
        if (accept_in)
        begin
            case (phase_reg)
                PH_HEAD2:
                begin
                    if (rx == HDR1)
                    begin
                        phase_next = PH_BODY;
                        pos_next   = 9'd2;
                        sum_next   = HEAD_SUM;
                    end
                    else
                    begin
                        // A bad second header byte is never taken as a new first byte.
                        phase_next = PH_HUNT;
                        pos_next   = 9'd0;
                    end
                end
                PH_BODY:
                begin
                    if (pos_reg == 9'd3)
                    begin
                        len_next = rx;
                        sum_next = sum_reg + rx;
                        pos_next = pos_reg + 9'd1;
                    end
                    else if (pos_reg == len_end)
                    begin
                        run_start  = (sum_reg == rx);
                        phase_next = PH_HUNT;
                        pos_next   = 9'd0;
                        len_next   = 8'd0;
                        sum_next   = 8'd0;
                    end
                    else
                    begin
                        sum_next = sum_reg + rx;
                        pos_next = pos_reg + 9'd1;
                    end
                end
                default:
                begin
                    if (rx == HDR0)
                    begin
                        phase_next = PH_HEAD2;
                        pos_next   = 9'd1;
                    end
                    else
                    begin
                        phase_next = PH_HUNT;
                        pos_next   = 9'd0;
                    end
                end
            endcase
        end
    end

    // Big-endian words at fixed store places: gains from position 4 upward, and the
    // angles in the order x (positions 10/11), y (8/9), z (6/7).
    always_comb
    begin
        for (int i = 0; i < 9; i++)
        begin
            gain_word[i] = {store_reg[2 + 2 * i][7], store_reg[2 + 2 * i],
                            store_reg[3 + 2 * i]};
        end
        for (int j = 0; j < 3; j++)
        begin
            angle_word[j] = {store_reg[8 - 2 * j][7], store_reg[8 - 2 * j],
                             store_reg[9 - 2 * j]};
        end
    end

    assign func = store_reg[0];
    assign sub  = store_reg[2];

    always_comb
    begin
        case (func)
            FUNC_CAL:    run_count = (sub == SUB_GYRO || sub == SUB_MAG) ? 4'd1 : 4'd0;
            FUNC_REQ:    run_count = (sub == SUB_PID) ? 4'd1 : 4'd0;
            FUNC_ANGLE:  run_count = 4'd3;
            FUNC_GAIN:   run_count = 4'(RUN_MAX);
            FUNC_ACK_LO, FUNC_ACK_2, FUNC_ACK_3, FUNC_ACK_4, FUNC_ACK_HI:
                         run_count = 4'd1;
            default:     run_count = 4'd0;
        endcase
    end

    assign out_free  = !out_valid_reg || act.ready;
    assign load      = run_active_reg && out_free && (run_count != 4'd0);
    assign load_last = (idx_reg == run_count - 4'd1);

    // Run sequencer: one action into the result register per free cycle.
    always_comb
    begin
        run_active_next = run_active_reg;
        idx_next        = idx_reg;
        out_valid_next  = out_valid_reg && !act.ready;
        out_action_next = out_action_reg;
        out_slot_next   = out_slot_reg;
        out_value_next  = out_value_reg;
        out_sum_next    = out_sum_reg;
        out_last_next   = out_last_reg;

        if (run_start)
        begin
            run_active_next = 1'b1;
            idx_next        = 4'd0;
        end
        else if (run_active_reg && run_count == 4'd0)
        begin
            // A matching frame with an unknown function or sub-command gives no actions.
            run_active_next = 1'b0;
        end
        else if (load)
        begin
            out_valid_next  = 1'b1;
            out_last_next   = load_last;
            out_slot_next   = '0;
            out_value_next  = '0;
            out_sum_next    = '0;
            out_action_next = ACT_ACK;
            case (func)
                FUNC_CAL:
                begin
                    out_action_next = (sub == SUB_GYRO) ? ACT_GYRO_CAL : ACT_MAG_CAL;
                end
                FUNC_REQ:
                begin
                    out_action_next = ACT_PID_REQ;
                end
                FUNC_ANGLE:
                begin
                    out_action_next = ACT_ANGLE;
                    out_slot_next   = idx_reg;
                    out_value_next  = VALUE_W'(17'd0 - angle_word[idx_reg[1:0]]);
                end
                FUNC_GAIN:
                begin
                    if (idx_reg < 4'd9)
                    begin
                        out_action_next = ACT_GAIN;
                        out_slot_next   = idx_reg;
                        out_value_next  = gain_word[idx_reg];
                    end
                    else if (idx_reg == 4'd9)
                    begin
                        out_action_next = ACT_ACK;
                        out_value_next  = {9'd0, func};
                        out_sum_next    = run_sum_reg;
                    end
                    else
                    begin
                        out_action_next = ACT_SAVE;
                    end
                end
                default:
                begin
                    out_action_next = ACT_ACK;
                    out_value_next  = {9'd0, func};
                    out_sum_next    = run_sum_reg;
                end
            endcase
            if (load_last)
            begin
                run_active_next = 1'b0;
                idx_next        = 4'd0;
            end
            else
            begin
                idx_next = idx_reg + 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_HUNT;
            pos_reg        <= '0;
            len_reg        <= '0;
            sum_reg        <= '0;
            for (int k = 0; k < STORED_BYTES; k++)
            begin
                store_reg[k] <= '0;
            end
            run_active_reg <= 1'b0;
            idx_reg        <= '0;
            run_sum_reg    <= '0;
            out_valid_reg  <= 1'b0;
            out_action_reg <= '0;
            out_slot_reg   <= '0;
            out_value_reg  <= '0;
            out_sum_reg    <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            len_reg   <= len_next;
            sum_reg   <= sum_next;
            if (store_we)
            begin
                store_reg[wr_idx] <= rx;
            end
            if (run_start)
            begin
                run_sum_reg <= sum_reg;
            end
            run_active_reg <= run_active_next;
            idx_reg        <= idx_next;
            out_valid_reg  <= out_valid_next;
            out_action_reg <= out_action_next;
            out_slot_reg   <= out_slot_next;
            out_value_reg  <= out_value_next;
            out_sum_reg    <= out_sum_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign act.valid   = out_valid_reg;
    assign act.action  = out_action_reg;
    assign act.slot    = out_slot_reg;
    assign act.value   = out_value_reg;
    assign act.ack_sum = out_sum_reg;
    assign act.last    = out_last_reg;

    // The position never runs past the check byte of the frame in progress.
    `TCD_ASSERT_IMPLY(a_pos_bound, phase_reg == PH_BODY, pos_reg <= len_end)
    // Hunting always sits at position zero.
    `TCD_ASSERT_IMPLY(a_hunt_pos, phase_reg == PH_HUNT, pos_reg == 9'd0)
    // A matching check byte always opens a run and so holds off the byte channel.
    `TCD_ASSERT_NEXT(a_run_opens, run_start, run_active_reg && !cmd.ready)
    // The run index stays inside the longest run.
    `TCD_ASSERT_IMPLY(a_run_idx, run_active_reg, idx_reg < 4'(RUN_MAX))

endmodule

`default_nettype wire

>>> tb/deframer_action_check.sv
module deframer_action_check #(
    parameter int STORED_BYTES = tcd_pkg::STORED_BYTES_DEF
) (
    input  logic clk,
    input  logic rst_n,
    tcd_in_if    cmd,
    tcd_out_if   act,
    output int   mismatch_count,
    output int   actions_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import tcd_pkg::*;

    localparam int GAIN_COUNT = 9;

    typedef enum logic [1:0] {SYNC_HUNT, SYNC_HEAD2, SYNC_BODY} sync_phase_t;

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [SLOT_W-1:0]   slot;
        logic [VALUE_W-1:0]  value;
        logic [BYTE_W-1:0]   ack_sum;
        logic                last;
    } action_beat_t;

    sync_phase_t       phase;
    logic [8:0]        byte_pos;
    logic [BYTE_W-1:0] frame_len;
    logic [BYTE_W-1:0] running_sum;
    logic [BYTE_W-1:0] frame_mem [STORED_BYTES];
    action_beat_t      expected_actions [$];

    // Positions outside the kept window read as zero.
    function automatic logic [BYTE_W-1:0] stored_at(int pos);
        if (pos < 2 || pos - 2 >= STORED_BYTES)
            return '0;
        return frame_mem[pos - 2];
    endfunction

    // Big-endian 16-bit word, sign-extended to the value width.
    function automatic logic [VALUE_W-1:0] be_word(int pos);
        logic [15:0] w;
        w = {stored_at(pos), stored_at(pos + 1)};
        return {w[15], w};
    endfunction

    function automatic action_beat_t make_beat(logic [ACTION_W-1:0] action, int slot,
                                               logic [VALUE_W-1:0] value,
                                               logic [BYTE_W-1:0] ack_sum);
        action_beat_t beat;
        beat.action  = action;
        beat.slot    = SLOT_W'(slot);
        beat.value   = value;
        beat.ack_sum = ack_sum;
        beat.last    = 1'b0;
        return beat;
    endfunction

    always @(posedge clk or negedge rst_n) begin : predict_and_compare
        action_beat_t      seen;
        action_beat_t      want;
        action_beat_t      run [$];
        logic [BYTE_W-1:0] b;
        logic [BYTE_W-1:0] func;
        logic [BYTE_W-1:0] sub;

        if (!rst_n) begin
            phase       = SYNC_HUNT;
            byte_pos    = '0;
            frame_len   = '0;
            running_sum = '0;
            for (int k = 0; k < STORED_BYTES; k++)
                frame_mem[k] = '0;
            expected_actions.delete();
            mismatch_count  = 0;
            actions_pending <= 0;
        end else begin
            // Output beats are compared before this edge's input byte is absorbed, so a
            // run can never be matched against expectations it has not yet earned.
            if (act.valid && act.ready) begin
                seen = '{action: act.action, slot: act.slot, value: act.value,
                         ack_sum: act.ack_sum, last: act.last};
                if (expected_actions.size() == 0) begin
                    $display("%0t: unexpected action beat: action %0d slot %0d value %0d sum %0d last %0d",
                             $realtime, seen.action, seen.slot, $signed(seen.value),
                             seen.ack_sum, seen.last);
                    mismatch_count++;
                end else begin
                    want = expected_actions.pop_front();
                    if (seen !== want) begin
                        $display("%0t: action mismatch: expected action %0d slot %0d value %0d sum %0d last %0d",
                                 $realtime, want.action, want.slot, $signed(want.value),
                                 want.ack_sum, want.last);
                        $display("%0t:                  actual action %0d slot %0d value %0d sum %0d last %0d",
                                 $realtime, seen.action, seen.slot, $signed(seen.value),
                                 seen.ack_sum, seen.last);
                        mismatch_count++;
                    end
                end
            end

            if (cmd.valid && cmd.ready) begin
                b = cmd.rx_byte;
                case (phase)
                    SYNC_HEAD2: begin
                        if (b == HDR1) begin
                            phase       = SYNC_BODY;
                            byte_pos    = 9'd2;
                            running_sum = HEAD_SUM;
                        end else begin
                            phase    = SYNC_HUNT;
                            byte_pos = '0;
                        end
                    end
                    SYNC_BODY: begin
                        if (byte_pos >= 2 && byte_pos - 2 < STORED_BYTES)
                            frame_mem[byte_pos - 2] = b;
                        if (byte_pos == 9'd3) begin
                            frame_len   = b;
                            running_sum = running_sum + b;
                            byte_pos    = byte_pos + 9'd1;
                        end else if (byte_pos == frame_len + 9'd4) begin
                            if (running_sum == b) begin
                                run.delete();
                                func = stored_at(2);
                                sub  = stored_at(4);
                                if (func == FUNC_CAL) begin
                                    if (sub == SUB_GYRO)
                                        run.push_back(make_beat(ACT_GYRO_CAL, 0, '0, '0));
                                    if (sub == SUB_MAG)
                                        run.push_back(make_beat(ACT_MAG_CAL, 0, '0, '0));
                                end else if (func == FUNC_REQ) begin
                                    if (sub == SUB_PID)
                                        run.push_back(make_beat(ACT_PID_REQ, 0, '0, '0));
                                end else if (func == FUNC_ANGLE) begin
                                    // Axes come out x, y, z from the back of the payload.
                                    run.push_back(make_beat(ACT_ANGLE, 0, -be_word(10), '0));
                                    run.push_back(make_beat(ACT_ANGLE, 1, -be_word(8), '0));
                                    run.push_back(make_beat(ACT_ANGLE, 2, -be_word(6), '0));
                                end else if (func == FUNC_GAIN) begin
                                    for (int i = 0; i < GAIN_COUNT; i++)
                                        run.push_back(make_beat(ACT_GAIN, i, be_word(4 + 2 * i),
                                                                '0));
                                    run.push_back(make_beat(ACT_ACK, 0, VALUE_W'(func),
                                                            running_sum));
                                    run.push_back(make_beat(ACT_SAVE, 0, '0, '0));
                                end else if (func >= FUNC_ACK_LO && func <= FUNC_ACK_HI) begin
                                    run.push_back(make_beat(ACT_ACK, 0, VALUE_W'(func),
                                                            running_sum));
                                end
                                if (run.size() != 0) begin
                                    run[run.size() - 1].last = 1'b1;
                                    foreach (run[i])
                                        expected_actions.push_back(run[i]);
                                end
                            end
                            phase       = SYNC_HUNT;
                            byte_pos    = '0;
                            frame_len   = '0;
                            running_sum = '0;
                        end else begin
                            running_sum = running_sum + b;
                            byte_pos    = byte_pos + 9'd1;
                        end
                    end
                    default: begin
                        if (b == HDR0) begin
                            phase    = SYNC_HEAD2;
                            byte_pos = 9'd1;
                        end else begin
                            phase    = SYNC_HUNT;
                            byte_pos = '0;
                        end
                    end
                endcase
            end

            actions_pending <= expected_actions.size();
        end
    end

endmodule

>>> tb/testbench.sv
// Top of the command deframer bench. It only makes traffic and gives the verdict: the
// byte stream goes in on cmd, action beats are taken from act, and the action checker
// that sits beside the block predicts every run and compares it beat by beat.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import tcd_pkg::*;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 10;
    localparam int MAX_GAP      = 18;
    localparam int LONG_HOLD    = 300;
    localparam int RANDOM_ITEMS = 40;
    localparam int TAIL_CYCLES  = 40;
    localparam int TIMEOUT_NS   = 2_000_000;

    logic clk;
    logic rst_n;

    tcd_in_if  cmd ();
    tcd_out_if act ();

    int mismatch_count;
    int actions_pending;

    // When set, the sender offers its bytes back to back with no idle cycles.
    bit sender_calm;

    // The stimulus asks for one long hold-off of act; the receiver takes it once.
    bit long_hold_wanted;
    bit long_hold_taken;

    // Bytes of the frame being built, numbered as the block numbers frame positions.
    logic [BYTE_W-1:0] frame_bytes [$];

    telemetry_command_deframer DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd),
        .act   (act)
    );

    deframer_action_check action_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .act             (act),
        .mismatch_count  (mismatch_count),
        .actions_pending (actions_pending)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Offers one byte after a random idle gap and returns at the edge that takes it.
    // Inputs only change at rising edges, so ready seen at the falling edge is what
    // the next rising edge will see.
    task automatic drive_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = sender_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            cmd.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd.valid   <= 1'b1;
        cmd.rx_byte <= b;
        do @(negedge clk); while (!cmd.ready);
        @(posedge clk);
    endtask

    // Header, function code and length, followed by a random payload of that length.
    task automatic start_frame(input logic [BYTE_W-1:0] func, input int len);
        frame_bytes.delete();
        frame_bytes.push_back(HDR0);
        frame_bytes.push_back(HDR1);
        frame_bytes.push_back(func);
        frame_bytes.push_back(BYTE_W'(len));
        repeat (len) frame_bytes.push_back(BYTE_W'($urandom));
    endtask

    task automatic put_word(input int pos, input logic [15:0] w);
        frame_bytes[pos]     = w[15:8];
        frame_bytes[pos + 1] = w[7:0];
    endtask

    // Appends the check byte, correct or deliberately corrupted, and sends the frame.
    task automatic send_frame(input bit good_sum);
        logic [BYTE_W-1:0] sum;
        sum = '0;
        foreach (frame_bytes[i])
            sum = sum + frame_bytes[i];
        if (!good_sum)
            sum = sum ^ BYTE_W'($urandom_range(1, 255));
        frame_bytes.push_back(sum);
        foreach (frame_bytes[i])
            drive_byte(frame_bytes[i]);
    endtask

    // The sender goes quiet until every predicted action beat has been taken. The first
    // edge lets the checker's count catch up with the byte accepted just before.
    task automatic wait_drained();
        cmd.valid <= 1'b0;
        @(posedge clk);
        while (actions_pending != 0) @(posedge clk);
    endtask

    initial
    begin : stimulus
        logic [BYTE_W-1:0] func;
        logic [BYTE_W-1:0] junk;
        int                len;
        int                random_items;

        clk              = 1'b0;
        rst_n            = 1'b0;
        cmd.valid        = 1'b0;
        cmd.rx_byte      = '0;
        sender_calm      = 1'b0;
        long_hold_wanted = 1'b0;
        random_items     = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Calibrate and report requests, plus a calibrate frame with a sub-command that
        // must be dropped.
        start_frame(FUNC_CAL, 1);
        frame_bytes[4] = SUB_GYRO;
        send_frame(1'b1);
        start_frame(FUNC_CAL, 1);
        frame_bytes[4] = SUB_MAG;
        send_frame(1'b1);
        start_frame(FUNC_REQ, 1);
        frame_bytes[4] = SUB_PID;
        send_frame(1'b1);
        start_frame(FUNC_CAL, 1);
        frame_bytes[4] = SUB_PID;
        send_frame(1'b1);

        // Target angles at the edges of the signed range; negating the most negative
        // angle needs the seventeenth bit.
        start_frame(FUNC_ANGLE, 8);
        put_word(6, 16'h8000);
        put_word(8, 16'h7FFF);
        put_word(10, 16'h0000);
        send_frame(1'b1);
        start_frame(FUNC_ANGLE, 8);
        put_word(6, 16'hFFFF);
        put_word(8, 16'h0001);
        put_word(10, 16'h8001);
        send_frame(1'b1);

        // A gain frame with extreme gains, then every acknowledge-only code.
        start_frame(FUNC_GAIN, 18);
        put_word(4, 16'h8000);
        put_word(6, 16'h7FFF);
        put_word(8, 16'h0000);
        put_word(10, 16'hFFFF);
        send_frame(1'b1);
        for (int f = FUNC_ACK_LO; f <= FUNC_ACK_HI; f++)
        begin
            start_frame(BYTE_W'(f), 0);
            send_frame(1'b1);
        end

        // A bad check byte, and function codes that mean nothing, are dropped.
        start_frame(FUNC_GAIN, 18);
        send_frame(1'b0);
        start_frame(8'h00, 2);
        send_frame(1'b1);
        start_frame(8'hFF, 0);
        send_frame(1'b1);

        // A lone first header byte in front of a good frame: the frame's own 0xAA is
        // the bad second byte and must not restart the header, so nothing comes out.
        drive_byte(HDR0);
        start_frame(FUNC_ACK_LO, 0);
        send_frame(1'b1);
        drive_byte(HDR0);
        drive_byte(8'h00);

        // Header bytes inside a payload are plain data.
        start_frame(FUNC_ACK_2, 4);
        frame_bytes[4] = HDR0;
        frame_bytes[5] = HDR1;
        frame_bytes[6] = HDR0;
        frame_bytes[7] = 8'hFF;
        send_frame(1'b1);

        // A frame longer than the store, then short frames that decode what is left in it.
        start_frame(FUNC_GAIN, 40);
        send_frame(1'b1);
        start_frame(FUNC_ANGLE, 0);
        send_frame(1'b1);
        start_frame(FUNC_GAIN, 0);
        send_frame(1'b1);

        wait_drained();

        // Pressure: the receiver holds act off for a long stretch while gain frames keep
        // coming back to back, so the pending run blocks cmd.
        long_hold_wanted = 1'b1;
        sender_calm      = 1'b1;
        repeat (3)
        begin
            start_frame(FUNC_GAIN, 18);
            send_frame(1'b1);
        end
        sender_calm = 1'b0;
        wait_drained();

        // Random traffic: mostly well-formed frames with random content, some noise
        // and broken headers. The directed part above already sends about 270 bytes; the random
        // budget starts from zero, and only frame bytes count toward it.
        while (random_items < RANDOM_ITEMS)
        begin
            sender_calm = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 11))
                0:
                begin
                    repeat ($urandom_range(1, 6))
                        drive_byte(($urandom_range(0, 3) == 0) ? HDR0 : BYTE_W'($urandom));
                end
                1:
                begin
                    junk = BYTE_W'($urandom);
                    if (junk == HDR1)
                        junk = HDR0;
                    drive_byte(HDR0);
                    drive_byte(junk);
                end
                default:
                begin
                    case ($urandom_range(0, 7))
                        0:
                        begin
                            func = FUNC_CAL;
                            len  = 1;
                        end
                        1:
                        begin
                            func = FUNC_REQ;
                            len  = 1;
                        end
                        2:
                        begin
                            func = FUNC_ANGLE;
                            len  = 8;
                        end
                        3, 4:
                        begin
                            func = FUNC_GAIN;
                            len  = 18;
                        end
                        5, 6:
                        begin
                            func = BYTE_W'($urandom_range(FUNC_ACK_LO, FUNC_ACK_HI));
                            len  = $urandom_range(0, 6);
                        end
                        default:
                        begin
                            func = BYTE_W'($urandom);
                            len  = $urandom_range(0, 6);
                        end
                    endcase
                    if ($urandom_range(0, 3) == 0)
                        len = $urandom_range(0, 24);
                    if ($urandom_range(0, 15) == 0)
                        len = $urandom_range(25, 60);
                    start_frame(func, len);
                    // Give the sub-command byte a meaningful value most of the time.
                    if (len != 0 && $urandom_range(0, 3) != 0)
                    begin
                        case ($urandom_range(0, 2))
                            0:       frame_bytes[4] = SUB_PID;
                            1:       frame_bytes[4] = SUB_GYRO;
                            default: frame_bytes[4] = SUB_MAG;
                        endcase
                    end
                    send_frame($urandom_range(0, 7) != 0);
                    random_items += len + 5;
                end
            endcase
        end
        sender_calm = 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatch_count == 0 && actions_pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // The receiver waits a random number of cycles before each action beat, with calm
    // stretches where it never waits, and takes the one long hold-off when asked.
    initial
    begin : receiver
        int gap;
        int calm_left;

        act.ready       = 1'b0;
        long_hold_taken = 1'b0;
        calm_left       = 0;

        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_hold_wanted && !long_hold_taken)
            begin
                long_hold_taken = 1'b1;
                act.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else
            begin
                if (calm_left == 0 && $urandom_range(0, 7) == 0)
                    calm_left = $urandom_range(10, 40);
                if (calm_left > 0)
                begin
                    gap = 0;
                    calm_left--;
                end
                else
                begin
                    gap = $urandom_range(0, MAX_GAP);
                end
                if (gap > 0)
                begin
                    act.ready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            act.ready <= 1'b1;
            do @(negedge clk); while (!act.valid);
            @(posedge clk);
        end
    end

    // A hung handshake or a missing action beat ends the run here.
    initial
    begin : watchdog
        #(TIMEOUT_NS);
        $display("TB_ERROR");
        $finish;
    end

endmodule
